// File: rtl/rldq_pkg.sv
// Shared constants and result codes of the rate-limited deadline queue.
package rldq_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH_DEF  = 16;
  localparam int unsigned TIME_WIDTH_DEF   = 32;

  // Most due channels emitted on one tick.
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned CH_W       = 6;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned DL_OUT_W   = 32;
  localparam int unsigned KIND_W     = 3;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd30;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_QUEUED  = 3'd0,
    KIND_DUP     = 3'd1,
    KIND_IGNORED = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_DUE     = 3'd4
  } kind_e;

  // Input op codes.
  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

endpackage

// File: rtl/rldq_ram.sv
// Simple dual-port memory: one write port, one registered read port.
module rldq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/rate_limited_deadline_queue_core.sv
// Top level of the rate-limited deadline queue: sequencer, time counter and result register.
//
// Usage:
// The slave stream carries one item per handshake: tuser[0] is the op (request or
// one-second tick), tuser[1] marks a message-kind channel, tdata[5:0] is the channel.
// A request gives exactly one result (queued, duplicate, ignored or queue full).
// A tick advances the seconds counter and emits every due head entry, up to
// MAX_RESULTS of them, or nothing when none is due; tlast marks the final result.
// The master stream carries the kind in tuser and the channel and deadline in tdata.
// Items are handled one at a time. A request walks the queue memory through its one
// read port: the duplicate/position scan reads each entry in turn, and the shift
// moves entries from the tail down to the insert position to open the slot. A tick
// pops due head entries one by one. The next item is taken as soon as the
// last result sits in the output register.
// A receiver stall holds the output register and stops the sequencer when it has
// another result to hand over. Reset clears the counter, the queue fill count and
// the ever-updated marks and sets the interval to 30 seconds; no clearing pass runs. The user
// writes the interval via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
module rate_limited_deadline_queue_core
  import rldq_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH   = TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Interval register write.
  input  logic                  cfg_we_i,
  input  logic [INTERVAL_W-1:0] cfg_wdata_i,
  // Request input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [5:0] channel, [7:6] zero
  input  logic [1:0]            s_axis_tuser,  // [0] op, [1] message_kind
  // Result output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // [5:0] channel_out, [37:6] deadline, [39:38] zero
  output logic [KIND_W-1:0]     m_axis_tuser,  // [2:0] kind
  output logic                  m_axis_tlast   // last
);

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned QA    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CH_AW = $clog2(NUM_CHANNELS);
  localparam int unsigned NW    = $clog2(MAX_RESULTS + 1);
  localparam int unsigned EW    = CH_W + TW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_READ,
    ST_T_CHECK,
    ST_R_LUT,
    ST_R_ELAPSED,
    ST_R_DEADLINE,
    ST_R_SCAN_RD,
    ST_R_SCAN_CHK,
    ST_R_FULL,
    ST_R_SHIFT_RD,
    ST_R_SHIFT_WR,
    ST_R_INSERT,
    ST_R_OUT
  } state_e;

  // Circular queue position of a logical index.
  function automatic logic [QA-1:0] phys(input logic [QA-1:0] h, input logic [CW-1:0] x);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(x);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[QA-1:0];
  endfunction

  // Time value cut or extended to the output deadline width.
  function automatic logic [DL_OUT_W-1:0] to_out(input logic [TW-1:0] t);
    logic [TW+DL_OUT_W-1:0] w;
    w = (TW+DL_OUT_W)'(t);
    return w[DL_OUT_W-1:0];
  endfunction

  // Channel number as a lookup address.
  function automatic logic [CH_AW-1:0] ch_addr(input logic [CH_W-1:0] c);
    logic [CH_AW+CH_W-1:0] w;
    w = (CH_AW+CH_W)'(c);
    return w[CH_AW-1:0];
  endfunction

  state_e                  state_q;
  logic [INTERVAL_W-1:0]   interval_q;
  logic [TW-1:0]           now_q;
  logic [QA-1:0]           head_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           idx_q;
  logic [CW-1:0]           pos_q;
  logic                    pos_found_q;
  logic [NW-1:0]           n_q;
  logic [NUM_CHANNELS-1:0] ever_q;
  logic [CH_W-1:0]         ch_q;
  logic [INTERVAL_W-1:0]   elapsed_q;
  logic [TW-1:0]           dl_q;
  kind_e                   res_kind_q;
  logic                    pend_valid_q;
  logic [CH_W-1:0]         pend_ch_q;

  logic                    out_valid_q;
  kind_e                   out_kind_q;
  logic [CH_W-1:0]         out_ch_q;
  logic [DL_OUT_W-1:0]     out_dl_q;
  logic                    out_last_q;

  // Memory ports.
  logic                    q_we;
  logic [QA-1:0]           q_waddr;
  logic [EW-1:0]           q_wdata;
  logic [QA-1:0]           q_raddr;
  logic [EW-1:0]           q_rdata;
  logic                    lut_we;
  logic [CH_AW-1:0]        lut_waddr;
  logic [TW-1:0]           lut_rdata;

  logic                    slot_free;
  logic                    accept;
  logic [CH_W-1:0]         in_ch;
  logic                    in_ch_ok;
  logic [CH_W-1:0]         ent_ch;
  logic [TW-1:0]           ent_dl;
  logic [TW-1:0]           due_diff;
  logic                    due;
  logic                    pop;
  logic [TW-1:0]           age;
  logic [INTERVAL_W-1:0]   elapsed_d;
  logic [TW-1:0]           ins_diff;
  logic                    ins_here;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_ch = s_axis_tdata[CH_W-1:0];
  assign in_ch_ok = (32'(in_ch) < 32'(NUM_CHANNELS));

  assign ent_ch = q_rdata[EW-1:TW];
  assign ent_dl = q_rdata[TW-1:0];

  // Head is due when its deadline minus now is zero or negative.
  assign due_diff = ent_dl - now_q;
  assign due = (count_q != '0) && (n_q < NW'(MAX_RESULTS)) &&
               ((due_diff == '0) || due_diff[TW-1]);
  assign pop = (state_q == ST_T_CHECK) && due && (!pend_valid_q || slot_free);

  // Elapsed time since the last update, clamped to the interval.
  assign age = now_q - lut_rdata;
  always_comb begin
    if (!ever_q[ch_addr(ch_q)]) begin
      elapsed_d = interval_q;
    end else if (age[TW-1]) begin
      elapsed_d = '0;
    end else if (age > TW'(interval_q)) begin
      elapsed_d = interval_q;
    end else begin
      elapsed_d = age[INTERVAL_W-1:0];
    end
  end

  // Insertion point: first entry whose deadline is not earlier than the new one.
  assign ins_diff = dl_q - ent_dl;
  assign ins_here = !((ins_diff != '0) && !ins_diff[TW-1]);

  // Queue memory addressing.
  always_comb begin
    unique case (state_q)
      ST_R_SHIFT_RD, ST_R_SHIFT_WR: q_raddr = phys(head_q, idx_q - CW'(1));
      ST_R_SCAN_RD, ST_R_SCAN_CHK:  q_raddr = phys(head_q, idx_q);
      default:                      q_raddr = head_q;
    endcase
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = phys(head_q, idx_q);
    q_wdata = q_rdata;
    if (state_q == ST_R_SHIFT_WR) begin
      q_we = 1'b1;
    end else if (state_q == ST_R_INSERT) begin
      q_we    = 1'b1;
      q_waddr = phys(head_q, pos_q);
      q_wdata = {ch_q, dl_q};
    end
  end

  assign lut_we    = pop;
  assign lut_waddr = ch_addr(ent_ch);

  rldq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  rldq_ram #(
    .DEPTH (NUM_CHANNELS),
    .WIDTH (TW)
  ) u_lut_ram (
    .clk_i   (clk_i),
    .we_i    (lut_we),
    .waddr_i (lut_waddr),
    .wdata_i (now_q),
    .raddr_i (ch_addr(ch_q)),
    .rdata_o (lut_rdata)
  );

  // Sequencer, queue bookkeeping and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      interval_q   <= INTERVAL_RESET;
      now_q        <= '0;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      pos_found_q  <= 1'b0;
      n_q          <= '0;
      ever_q       <= '0;
      ch_q         <= '0;
      elapsed_q    <= '0;
      dl_q         <= '0;
      res_kind_q   <= KIND_QUEUED;
      pend_valid_q <= 1'b0;
      pend_ch_q    <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_QUEUED;
      out_ch_q     <= '0;
      out_dl_q     <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end

      // Result taken downstream; a load below overrides this.
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ch_q <= in_ch;
            if (s_axis_tuser[0] == OP_TICK) begin
              now_q        <= now_q + TW'(1);
              n_q          <= '0;
              pend_valid_q <= 1'b0;
              state_q      <= ST_T_READ;
            end else if (!s_axis_tuser[1] || !in_ch_ok) begin
              res_kind_q <= KIND_IGNORED;
              dl_q       <= '0;
              state_q    <= ST_R_OUT;
            end else begin
              state_q <= ST_R_LUT;
            end
          end
        end

        ST_T_READ: begin
          state_q <= ST_T_CHECK;
        end

        ST_T_CHECK: begin
          if (!pend_valid_q || slot_free) begin
            if (pend_valid_q) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= KIND_DUE;
              out_ch_q    <= pend_ch_q;
              out_dl_q    <= to_out(now_q);
              out_last_q  <= !due;
            end
            if (due) begin
              head_q                 <= phys(head_q, CW'(1));
              count_q                <= count_q - CW'(1);
              ever_q[ch_addr(ent_ch)] <= 1'b1;
              pend_valid_q           <= 1'b1;
              pend_ch_q              <= ent_ch;
              n_q                    <= n_q + NW'(1);
              state_q                <= ST_T_READ;
            end else begin
              pend_valid_q <= 1'b0;
              state_q      <= ST_IDLE;
            end
          end
        end

        ST_R_LUT: begin
          state_q <= ST_R_ELAPSED;
        end

        ST_R_ELAPSED: begin
          elapsed_q <= elapsed_d;
          state_q   <= ST_R_DEADLINE;
        end

        ST_R_DEADLINE: begin
          dl_q        <= now_q + TW'(interval_q - elapsed_q);
          idx_q       <= '0;
          pos_q       <= count_q;
          pos_found_q <= 1'b0;
          state_q     <= ST_R_SCAN_RD;
        end

        ST_R_SCAN_RD: begin
          if (idx_q == count_q) begin
            state_q <= ST_R_FULL;
          end else begin
            state_q <= ST_R_SCAN_CHK;
          end
        end

        ST_R_SCAN_CHK: begin
          if (ent_ch == ch_q) begin
            res_kind_q <= KIND_DUP;
            dl_q       <= '0;
            state_q    <= ST_R_OUT;
          end else begin
            if (!pos_found_q && ins_here) begin
              pos_q       <= idx_q;
              pos_found_q <= 1'b1;
            end
            idx_q   <= idx_q + CW'(1);
            state_q <= ST_R_SCAN_RD;
          end
        end

        ST_R_FULL: begin
          if (count_q >= CW'(QUEUE_DEPTH)) begin
            res_kind_q <= KIND_FULL;
            dl_q       <= '0;
            state_q    <= ST_R_OUT;
          end else begin
            idx_q   <= count_q;
            state_q <= ST_R_SHIFT_RD;
          end
        end

        ST_R_SHIFT_RD: begin
          if (idx_q == pos_q) begin
            state_q <= ST_R_INSERT;
          end else begin
            state_q <= ST_R_SHIFT_WR;
          end
        end

        ST_R_SHIFT_WR: begin
          idx_q   <= idx_q - CW'(1);
          state_q <= ST_R_SHIFT_RD;
        end

        ST_R_INSERT: begin
          count_q    <= count_q + CW'(1);
          res_kind_q <= KIND_QUEUED;
          state_q    <= ST_R_OUT;
        end

        ST_R_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= res_kind_q;
            out_ch_q    <= ch_q;
            out_dl_q    <= to_out(dl_q);
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_dl_q, out_ch_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
